// ===== sv/bcl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcl_pkg
// Shared types and constants of the block-to-line comment converter.
// ----------------------------------------------------------------------------
package bcl_pkg;

   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_NL    = 8'h0A;

   localparam int SLOTS       = 4;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [QUEUE_PTR_W-1:0] QUEUE_LAST_PTR = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_W-1:0] QUEUE_FULL_CNT = QUEUE_CNT_W'(QUEUE_DEPTH);

   typedef enum logic [6:0] {
      MODE_PLAIN  = 7'b0000001,
      MODE_SLASH  = 7'b0000010,
      MODE_BLOCK  = 7'b0000100,
      MODE_STAR   = 7'b0001000,
      MODE_CLOSED = 7'b0010000,
      MODE_LINE   = 7'b0100000,
      MODE_DONE   = 7'b1000000
   } bcl_mode_type;

   // One run of results caused by one input transaction
   typedef struct packed {
      logic [SLOT_W-1:0]      last_slot;
      logic                   has_end;
      logic [SLOTS-1:0][7:0]  bytes;
   } bcl_entry_type;

   typedef struct packed {
      logic not_empty;
      logic not_full;
   } bcl_q_status_type;

endpackage

// ===== sv/bcl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcl_req_if / bcl_rsp_if
// Valid/ready channels for source text and converted results.
// ----------------------------------------------------------------------------
interface bcl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_input;

   modport source (output valid, output text_byte, output end_of_input, input ready);
   modport sink   (input valid, input text_byte, input end_of_input, output ready);
endinterface

interface bcl_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       char_valid;
   logic       run_last;
   logic       stream_done;

   modport source (output valid, output out_char, output char_valid, output run_last,
                   output stream_done, input ready);
   modport sink   (input valid, input out_char, input char_valid, input run_last,
                   input stream_done, output ready);
endinterface

// ===== sv/block_comment_to_line_comment_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_comment_to_line_comment_unit
// Rewrites C block comments in a byte stream as C++ line comments.
//
// req_chan carries one source byte (text_byte) or an end mark (end_of_input)
// per transaction. rsp_chan carries one result per transaction: out_char,
// char_valid (0 on the bare end marker), run_last on the last result of an
// input, and stream_done on the end marker.
// Throughput: one input per cycle while the four-entry run queue has room;
// the output side sends one result per cycle while the receiver is ready,
// so an input that yields k results holds the output for all k of them, and
// the queue absorbs the bursts. Inputs that yield no result (a held slash or
// star, anything after the end) use only the input side.
// A run is offered once registered in the run queue, after earlier runs.
// Reset: scanner returns to plain code, queue empties, nothing is offered.
// A stalled receiver holds the current result; the scanner keeps taking
// input until the queue is full, then drops req_chan.ready.
// ----------------------------------------------------------------------------
module block_comment_to_line_comment_unit (
   input  logic      clock,
   input  logic      reset,
   bcl_req_if.sink   req_chan,
   bcl_rsp_if.source rsp_chan
);

   bcl_pkg::bcl_q_status_type q_status;
   bcl_pkg::bcl_entry_type    push_entry;
   bcl_pkg::bcl_entry_type    head_entry;
   logic                      push;
   logic                      pop;

   bcl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   bcl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   bcl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .q_status   (q_status),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

endmodule

// ===== sv/bcl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcl_front
// Scanner: accepts one byte per cycle while the queue has room, tracks comment mode, builds result runs.
// ----------------------------------------------------------------------------
module bcl_front (
   input  logic                      clock,
   input  logic                      reset,
   bcl_req_if.sink                   req,
   input  bcl_pkg::bcl_q_status_type q_status,
   output logic                      push,
   output bcl_pkg::bcl_entry_type    push_entry
);

   bcl_pkg::bcl_mode_type mode_ff, mode_in;
   bcl_pkg::bcl_mode_type mode_next;
   bcl_pkg::bcl_entry_type entry;
   logic       emit;
   logic       accept;
   logic [7:0] c;
   logic       eoi;

   assign req.ready = q_status.not_full;
   assign accept    = req.valid && req.ready;
   assign c         = req.text_byte;
   assign eoi       = req.end_of_input;

   always_comb begin
      entry     = '0;
      emit      = 1'b0;
      mode_next = mode_ff;
      unique case (mode_ff)
         bcl_pkg::MODE_PLAIN: begin
            if (eoi) begin
               emit = 1'b1; entry.has_end = 1'b1;
               mode_next = bcl_pkg::MODE_DONE;
            end else if (c == bcl_pkg::CH_SLASH) begin
               mode_next = bcl_pkg::MODE_SLASH;
            end else begin
               emit = 1'b1; entry.bytes[0] = c;
            end
         end
         bcl_pkg::MODE_SLASH: begin
            emit = 1'b1;
            entry.bytes[0]  = bcl_pkg::CH_SLASH;
            entry.last_slot = bcl_pkg::SLOT_W'(1);
            if (eoi) begin
               entry.has_end = 1'b1;
               mode_next = bcl_pkg::MODE_DONE;
            end else if (c == bcl_pkg::CH_STAR) begin
               entry.bytes[1] = bcl_pkg::CH_SLASH;
               mode_next = bcl_pkg::MODE_BLOCK;
            end else if (c == bcl_pkg::CH_SLASH) begin
               entry.bytes[1] = bcl_pkg::CH_SLASH;
               mode_next = bcl_pkg::MODE_LINE;
            end else begin
               entry.bytes[1] = c;
               mode_next = bcl_pkg::MODE_PLAIN;
            end
         end
         bcl_pkg::MODE_BLOCK: begin
            if (eoi) begin
               emit = 1'b1; entry.has_end = 1'b1;
               mode_next = bcl_pkg::MODE_DONE;
            end else if (c == bcl_pkg::CH_STAR) begin
               mode_next = bcl_pkg::MODE_STAR;
            end else if (c == bcl_pkg::CH_NL) begin
               emit = 1'b1;
               entry.bytes[0]  = bcl_pkg::CH_NL;
               entry.bytes[1]  = bcl_pkg::CH_SLASH;
               entry.bytes[2]  = bcl_pkg::CH_SLASH;
               entry.last_slot = bcl_pkg::SLOT_W'(2);
            end else begin
               emit = 1'b1; entry.bytes[0] = c;
            end
         end
         bcl_pkg::MODE_STAR: begin
            entry.bytes[0] = bcl_pkg::CH_STAR;
            if (eoi) begin
               emit = 1'b1; entry.has_end = 1'b1;
               entry.last_slot = bcl_pkg::SLOT_W'(1);
               mode_next = bcl_pkg::MODE_DONE;
            end else if (c == bcl_pkg::CH_SLASH) begin
               mode_next = bcl_pkg::MODE_CLOSED;
            end else if (c == bcl_pkg::CH_STAR) begin
               emit = 1'b1;
               mode_next = bcl_pkg::MODE_STAR;
            end else if (c == bcl_pkg::CH_NL) begin
               emit = 1'b1;
               entry.bytes[1]  = bcl_pkg::CH_NL;
               entry.bytes[2]  = bcl_pkg::CH_SLASH;
               entry.bytes[3]  = bcl_pkg::CH_SLASH;
               entry.last_slot = bcl_pkg::SLOT_W'(3);
               mode_next = bcl_pkg::MODE_BLOCK;
            end else begin
               emit = 1'b1;
               entry.bytes[1]  = c;
               entry.last_slot = bcl_pkg::SLOT_W'(1);
               mode_next = bcl_pkg::MODE_BLOCK;
            end
         end
         bcl_pkg::MODE_CLOSED: begin
            emit = 1'b1;
            if (eoi) begin
               entry.bytes[0]  = bcl_pkg::CH_NL;
               entry.has_end   = 1'b1;
               entry.last_slot = bcl_pkg::SLOT_W'(1);
               mode_next = bcl_pkg::MODE_DONE;
            end else if (c == bcl_pkg::CH_NL) begin
               entry.bytes[0] = bcl_pkg::CH_NL;
               mode_next = bcl_pkg::MODE_PLAIN;
            end else begin
               entry.bytes[0]  = c;
               entry.bytes[1]  = bcl_pkg::CH_NL;
               entry.last_slot = bcl_pkg::SLOT_W'(1);
               mode_next = bcl_pkg::MODE_PLAIN;
            end
         end
         bcl_pkg::MODE_LINE: begin
            emit = 1'b1;
            if (eoi) begin
               entry.has_end = 1'b1;
               mode_next = bcl_pkg::MODE_DONE;
            end else begin
               entry.bytes[0] = c;
               if (c == bcl_pkg::CH_NL) mode_next = bcl_pkg::MODE_PLAIN;
            end
         end
         default: begin
            mode_next = bcl_pkg::MODE_DONE;
         end
      endcase
   end

   assign mode_in    = accept ? mode_next : mode_ff;
   assign push       = accept && emit;
   assign push_entry = entry;

   always_ff @(posedge clock) begin
      if (reset) mode_ff <= bcl_pkg::MODE_PLAIN;
      else       mode_ff <= mode_in;
   end

endmodule

// ===== sv/bcl_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcl_queue
// Short register queue of result runs between scanner and serialiser.
// ----------------------------------------------------------------------------
module bcl_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  bcl_pkg::bcl_entry_type    push_entry,
   input  logic                      pop,
   output bcl_pkg::bcl_entry_type    head_entry,
   output bcl_pkg::bcl_q_status_type status
);

   bcl_pkg::bcl_entry_type entries_ff [bcl_pkg::QUEUE_DEPTH];
   logic [bcl_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [bcl_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [bcl_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   assign status.not_empty = (count_ff != '0);
   assign status.not_full  = (count_ff != bcl_pkg::QUEUE_FULL_CNT);
   assign head_entry       = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == bcl_pkg::QUEUE_LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == bcl_pkg::QUEUE_LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_entry;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= bcl_pkg::QUEUE_FULL_CNT)
      else $error("queue count beyond depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> status.not_empty)
      else $error("pop from empty queue");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (status.not_full || pop))
      else $error("push into full queue");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");

endmodule

// ===== sv/bcl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcl_back
// Serialiser: sends the results of the head run one transaction per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module bcl_back (
   input  logic                      clock,
   input  logic                      reset,
   input  bcl_pkg::bcl_entry_type    head_entry,
   input  bcl_pkg::bcl_q_status_type q_status,
   output logic                      pop,
   bcl_rsp_if.source                 rsp
);

   logic [bcl_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic is_last;
   logic fire;

   assign is_last = (slot_ff == head_entry.last_slot);
   assign fire    = rsp.valid && rsp.ready;
   assign pop     = fire && is_last;

   assign rsp.valid       = q_status.not_empty;
   assign rsp.out_char    = head_entry.bytes[slot_ff];
   assign rsp.run_last    = is_last;
   assign rsp.stream_done = is_last && head_entry.has_end;
   assign rsp.char_valid  = !(is_last && head_entry.has_end);

   always_comb begin
      slot_in = slot_ff;
      if (fire) slot_in = is_last ? '0 : slot_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) slot_ff <= '0;
      else       slot_ff <= slot_in;
   end

   a_slot_rewind: assert property (@(posedge clock) disable iff (reset)
      pop |=> (slot_ff == '0))
      else $error("slot not rewound after run");

   a_slot_in_run: assert property (@(posedge clock) disable iff (reset)
      q_status.not_empty |-> (slot_ff <= head_entry.last_slot))
      else $error("slot beyond end of run");

   a_idle_slot: assert property (@(posedge clock) disable iff (reset)
      !q_status.not_empty |-> (slot_ff == '0))
      else $error("slot moved with empty queue");

endmodule

// ===== test/block_comment_to_line_comment_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_comment_to_line_comment_unit_tb
// Feeds C-like source text through the converter and compares every result
// transaction against a scoreboard that tracks the scanner mode itself.
// A directed opening covers the corner sequences. Random comment, code and
// noise segments follow, with random idle bursts on both channels and one
// long receiver hold-off. The stream ends with an end mark, and a few inputs
// after it must produce nothing.
// ----------------------------------------------------------------------------
module block_comment_to_line_comment_unit_tb;

   localparam int CLK_HALF       = 10;
   localparam int RESET_CYCLES   = 12;
   localparam int RANDOM_TARGET  = 405;
   localparam int QUIET_FROM     = 340;
   localparam int HOLD_AT        = 120;
   localparam int HOLD_CYCLES    = 50;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int AFTER_END_ITEMS = 6;

   typedef struct packed {
      logic [7:0] ch;
      logic       cv;
      logic       last;
      logic       done;
   } conv_result_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       eoi;
   } text_item_type;

   class comment_rewrite_board;
      bcl_pkg::bcl_mode_type mode;
      conv_result_type       pending_chars[$];
      conv_result_type       step_chars[$];
      int                    errors;

      function new();
         mode   = bcl_pkg::MODE_PLAIN;
         errors = 0;
      endfunction

      function void put_char(logic [7:0] c);
         step_chars.push_back('{c, 1'b1, 1'b0, 1'b0});
      endfunction

      function void put_end();
         step_chars.push_back('{8'h00, 1'b0, 1'b0, 1'b1});
         mode = bcl_pkg::MODE_DONE;
      endfunction

      function void comment_char(logic [7:0] c);
         if (c == bcl_pkg::CH_STAR) begin
            mode = bcl_pkg::MODE_STAR;
         end else if (c == bcl_pkg::CH_NL) begin
            put_char(bcl_pkg::CH_NL);
            put_char(bcl_pkg::CH_SLASH);
            put_char(bcl_pkg::CH_SLASH);
            mode = bcl_pkg::MODE_BLOCK;
         end else begin
            put_char(c);
            mode = bcl_pkg::MODE_BLOCK;
         end
      endfunction

      function void take_source_byte(logic [7:0] c, logic eoi);
         step_chars.delete();
         case (mode)
            bcl_pkg::MODE_PLAIN: begin
               if (eoi) put_end();
               else if (c == bcl_pkg::CH_SLASH) mode = bcl_pkg::MODE_SLASH;
               else put_char(c);
            end
            bcl_pkg::MODE_SLASH: begin
               if (eoi) begin
                  put_char(bcl_pkg::CH_SLASH);
                  put_end();
               end else if (c == bcl_pkg::CH_STAR) begin
                  put_char(bcl_pkg::CH_SLASH);
                  put_char(bcl_pkg::CH_SLASH);
                  mode = bcl_pkg::MODE_BLOCK;
               end else if (c == bcl_pkg::CH_SLASH) begin
                  put_char(bcl_pkg::CH_SLASH);
                  put_char(bcl_pkg::CH_SLASH);
                  mode = bcl_pkg::MODE_LINE;
               end else begin
                  put_char(bcl_pkg::CH_SLASH);
                  put_char(c);
                  mode = bcl_pkg::MODE_PLAIN;
               end
            end
            bcl_pkg::MODE_BLOCK: begin
               if (eoi) put_end();
               else comment_char(c);
            end
            bcl_pkg::MODE_STAR: begin
               if (eoi) begin
                  put_char(bcl_pkg::CH_STAR);
                  put_end();
               end else if (c == bcl_pkg::CH_SLASH) begin
                  mode = bcl_pkg::MODE_CLOSED;
               end else begin
                  put_char(bcl_pkg::CH_STAR);
                  comment_char(c);
               end
            end
            bcl_pkg::MODE_CLOSED: begin
               if (eoi) begin
                  put_char(bcl_pkg::CH_NL);
                  put_end();
               end else begin
                  if (c != bcl_pkg::CH_NL) put_char(c);
                  put_char(bcl_pkg::CH_NL);
                  mode = bcl_pkg::MODE_PLAIN;
               end
            end
            bcl_pkg::MODE_LINE: begin
               if (eoi) put_end();
               else begin
                  put_char(c);
                  if (c == bcl_pkg::CH_NL) mode = bcl_pkg::MODE_PLAIN;
               end
            end
            default: mode = bcl_pkg::MODE_DONE;
         endcase
         if (step_chars.size() > 0) step_chars[step_chars.size() - 1].last = 1'b1;
         foreach (step_chars[i]) pending_chars.push_back(step_chars[i]);
      endfunction

      function void match_output(logic [7:0] ch, logic cv, logic last, logic done);
         conv_result_type want;
         if (pending_chars.size() == 0) begin
            $display("%0t: unexpected result ch=%h cv=%b last=%b done=%b",
                     $time, ch, cv, last, done);
            errors++;
            return;
         end
         want = pending_chars.pop_front();
         if (want.ch !== ch || want.cv !== cv || want.last !== last || want.done !== done) begin
            $display("%0t: mismatch expected ch=%h cv=%b last=%b done=%b actual ch=%h cv=%b last=%b done=%b",
                     $time, want.ch, want.cv, want.last, want.done, ch, cv, last, done);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_chars.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   bcl_req_if req_chan ();
   bcl_rsp_if rsp_chan ();

   block_comment_to_line_comment_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   comment_rewrite_board board;
   text_item_type        source_q[$];
   int                   sent_count;
   bit                   idle_on;
   int                   quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0:       return bcl_pkg::CH_SLASH;
         1:       return bcl_pkg::CH_STAR;
         2:       return bcl_pkg::CH_NL;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic add_item(input logic [7:0] c, input logic eoi);
      source_q.push_back('{c, eoi});
   endtask

   task automatic build_source();
      int kind;
      int n;
      add_item(8'h00, 1'b0);
      add_item(8'hFF, 1'b0);
      add_item(bcl_pkg::CH_SLASH, 1'b0);
      add_item("b", 1'b0);
      add_item(bcl_pkg::CH_SLASH, 1'b0);
      add_item(bcl_pkg::CH_STAR, 1'b0);
      add_item("x", 1'b0);
      add_item(bcl_pkg::CH_NL, 1'b0);
      add_item(bcl_pkg::CH_STAR, 1'b0);
      add_item("a", 1'b0);
      add_item(bcl_pkg::CH_STAR, 1'b0);
      add_item(bcl_pkg::CH_NL, 1'b0);
      add_item(bcl_pkg::CH_STAR, 1'b0);
      add_item(bcl_pkg::CH_SLASH, 1'b0);
      add_item(bcl_pkg::CH_SLASH, 1'b0);
      add_item(bcl_pkg::CH_SLASH, 1'b0);
      add_item(bcl_pkg::CH_STAR, 1'b0);
      add_item(bcl_pkg::CH_STAR, 1'b0);
      add_item(bcl_pkg::CH_SLASH, 1'b0);
      add_item(bcl_pkg::CH_NL, 1'b0);
      add_item(bcl_pkg::CH_SLASH, 1'b0);
      add_item(bcl_pkg::CH_SLASH, 1'b0);
      add_item("q", 1'b0);
      add_item(bcl_pkg::CH_NL, 1'b0);
      while (source_q.size() < RANDOM_TARGET) begin
         kind = $urandom_range(0, 9);
         if (kind <= 2) begin
            n = $urandom_range(1, 8);
            repeat (n) add_item(($urandom_range(0, 3) == 0) ? pick_char()
                                : 8'($urandom_range(0, 255)), 1'b0);
         end else if (kind <= 6) begin
            add_item(bcl_pkg::CH_SLASH, 1'b0);
            add_item(bcl_pkg::CH_STAR, 1'b0);
            n = $urandom_range(0, 10);
            repeat (n) add_item(pick_char(), 1'b0);
            add_item(bcl_pkg::CH_STAR, 1'b0);
            add_item(bcl_pkg::CH_SLASH, 1'b0);
            add_item(pick_char(), 1'b0);
         end else if (kind <= 8) begin
            add_item(bcl_pkg::CH_SLASH, 1'b0);
            add_item(bcl_pkg::CH_SLASH, 1'b0);
            n = $urandom_range(0, 8);
            repeat (n) add_item(pick_char(), 1'b0);
            add_item(bcl_pkg::CH_NL, 1'b0);
         end else begin
            n = $urandom_range(1, 4);
            repeat (n) add_item($urandom_range(0, 1) ? bcl_pkg::CH_SLASH
                                : bcl_pkg::CH_STAR, 1'b0);
         end
      end
      case ($urandom_range(0, 5))
         0: ;
         1: add_item(bcl_pkg::CH_SLASH, 1'b0);
         2: begin
            add_item(bcl_pkg::CH_SLASH, 1'b0);
            add_item(bcl_pkg::CH_STAR, 1'b0);
            add_item("x", 1'b0);
         end
         3: begin
            add_item(bcl_pkg::CH_SLASH, 1'b0);
            add_item(bcl_pkg::CH_STAR, 1'b0);
            add_item(bcl_pkg::CH_STAR, 1'b0);
         end
         4: begin
            add_item(bcl_pkg::CH_SLASH, 1'b0);
            add_item(bcl_pkg::CH_STAR, 1'b0);
            add_item(bcl_pkg::CH_STAR, 1'b0);
            add_item(bcl_pkg::CH_SLASH, 1'b0);
         end
         default: begin
            add_item(bcl_pkg::CH_SLASH, 1'b0);
            add_item(bcl_pkg::CH_SLASH, 1'b0);
            add_item("y", 1'b0);
         end
      endcase
      add_item(8'($urandom_range(0, 255)), 1'b1);
      repeat (AFTER_END_ITEMS) add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   task automatic send_item(input text_item_type item);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.text_byte    <= item.ch;
      req_chan.end_of_input <= item.eoi;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      board.take_source_byte(item.ch, item.eoi);
      sent_count++;
      if (sent_count >= QUIET_FROM) idle_on = 1'b0;
   endtask

   // receiver: random stalls, one long hold once the run is under way
   initial begin
      int  stall_left;
      int  hold_left;
      bit  hold_done;
      logic next_ready;
      stall_left = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready)
            board.match_output(rsp_chan.out_char, rsp_chan.char_valid,
                               rsp_chan.run_last, rsp_chan.stream_done);
         if (!hold_done && sent_count >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 4) - 1;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
         end
         rsp_chan.ready <= next_ready;
      end
   end

   // watchdog: count cycles with no transaction on either channel
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("block_comment_to_line_comment_unit_tb failed");
            $finish;
         end
      end
   end

   initial begin
      board      = new();
      sent_count = 0;
      idle_on    = 1'b1;
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.text_byte    <= 8'h00;
      req_chan.end_of_input <= 1'b0;
      build_source();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      foreach (source_q[i]) send_item(source_q[i]);
      req_chan.valid <= 1'b0;
      while (board.outstanding() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("block_comment_to_line_comment_unit_tb passed");
      end else begin
         $display("block_comment_to_line_comment_unit_tb failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/bcl_pkg.sv
sv/bcl_if.sv
sv/bcl_front.sv
sv/bcl_queue.sv
sv/bcl_back.sv
sv/block_comment_to_line_comment_unit.sv
test/block_comment_to_line_comment_unit_tb.sv
